/* hdl/icmp_echo_reply_rewriter_unit_macros.svh */
// Assertion macros shared by the ICMP echo reply rewriter.
`ifndef ICMP_ECHO_REPLY_REWRITER_UNIT_MACROS_SVH
`define ICMP_ECHO_REPLY_REWRITER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ICMPR_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ICMPR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/icmpr_pkg.sv */
// Types and constants shared by the ICMP echo reply rewriter stages.
`timescale 1ns / 1ps
package icmpr_pkg;

  localparam int IN_DATA_W  = 280;
  localparam int OUT_DATA_W = 200;

  localparam logic [7:0]  PROTO_ICMP        = 8'h01;
  localparam logic [7:0]  ECHO_REQUEST      = 8'h08;
  localparam logic [7:0]  ECHO_REPLY        = 8'h00;
  localparam logic [7:0]  CODE_ZERO         = 8'h00;
  localparam logic [3:0]  MCAST_NIBBLE      = 4'hE;
  localparam logic [1:0]  SRC_LOW_ONE       = 2'b01;
  localparam logic [1:0]  SRC_LOW_TWO       = 2'b10;
  // complement of the request type/code word 0x0800
  localparam logic [15:0] ECHO_REQ_WORD_INV = 16'hF7FF;
  localparam logic [15:0] SUM_ALL_ONES      = 16'hFFFF;

  // after decode: flags, addresses, partial header sum, final ICMP sum
  typedef struct packed {
    logic        keep;
    logic        mcast;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [31:0] rsrc;
    logic [31:0] isrc;
    logic [15:0] hsum_in;
    logic [18:0] psum;
    logic [15:0] icmp_sum;
  } s1_t;

  // after summing: header sum folded once
  typedef struct packed {
    logic        keep;
    logic        mcast;
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [31:0] rsrc;
    logic [31:0] isrc;
    logic [15:0] hsum_in;
    logic [16:0] fsum;
    logic [15:0] icmp_sum;
  } s2_t;

endpackage

/* hdl/icmpr_decode.sv */
// Stage one: classify the request, pick the reply source, start the sums.
`timescale 1ns / 1ps
module icmpr_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [icmpr_pkg::IN_DATA_W-1:0] up_data,
  input  logic [7:0]                     up_kind,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output icmpr_pkg::s1_t                 dn_data
);
  import icmpr_pkg::*;

  logic        v_r;
  s1_t         d_r;
  s1_t         d_nxt;
  logic [63:0] front;
  logic [15:0] ttlp;
  logic [15:0] hsum_in;
  logic [31:0] isrc;
  logic [31:0] idst;
  logic [7:0]  subcode;
  logic [15:0] csum;
  logic [16:0] icmp_raw;
  logic [15:0] icmp_fold;

  assign front   = up_data[159:96];
  assign ttlp    = up_data[175:160];
  assign hsum_in = up_data[191:176];
  assign isrc    = up_data[223:192];
  assign idst    = up_data[255:224];
  assign subcode = up_data[263:256];
  assign csum    = up_data[279:264];

  // ~csum + ~0x0800; one fold is enough as the sum stays below 0x1F7FF
  assign icmp_raw  = {1'b0, ~csum} + {1'b0, ECHO_REQ_WORD_INV};
  assign icmp_fold = icmp_raw[15:0] + {15'b0, icmp_raw[16]};

  always_comb begin
    d_nxt.keep     = (ttlp[7:0] == PROTO_ICMP) && (up_kind == ECHO_REQUEST) &&
                     (subcode == CODE_ZERO);
    d_nxt.mcast    = (idst[31:28] == MCAST_NIBBLE);
    d_nxt.dmac     = up_data[47:0];
    d_nxt.smac     = up_data[95:48];
    d_nxt.isrc     = isrc;
    d_nxt.hsum_in  = hsum_in;
    if (d_nxt.mcast) begin
      d_nxt.rsrc = {isrc[31:2], (isrc[1:0] == SRC_LOW_ONE) ? SRC_LOW_TWO : SRC_LOW_ONE};
    end else begin
      d_nxt.rsrc = idst;
    end
    d_nxt.psum     = {3'b0, front[63:48]} + {3'b0, front[47:32]} +
                     {3'b0, front[31:16]} + {3'b0, front[15:0]} + {3'b0, ttlp};
    d_nxt.icmp_sum = ~icmp_fold;
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

/* hdl/icmpr_sum.sv */
// Stage two: add the address words to the header sum and fold once.
`timescale 1ns / 1ps
module icmpr_sum (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  icmpr_pkg::s1_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output icmpr_pkg::s2_t dn_data
);
  import icmpr_pkg::*;

  logic        v_r;
  s2_t         d_r;
  s2_t         d_nxt;
  logic [19:0] total;

  // nine 16-bit words fit in 20 bits
  assign total = {1'b0, up_data.psum} +
                 {4'b0, up_data.rsrc[31:16]} + {4'b0, up_data.rsrc[15:0]} +
                 {4'b0, up_data.isrc[31:16]} + {4'b0, up_data.isrc[15:0]};

  always_comb begin
    d_nxt.keep     = up_data.keep;
    d_nxt.mcast    = up_data.mcast;
    d_nxt.dmac     = up_data.dmac;
    d_nxt.smac     = up_data.smac;
    d_nxt.rsrc     = up_data.rsrc;
    d_nxt.isrc     = up_data.isrc;
    d_nxt.hsum_in  = up_data.hsum_in;
    d_nxt.fsum     = {1'b0, total[15:0]} + {13'b0, total[19:16]};
    d_nxt.icmp_sum = up_data.icmp_sum;
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

/* hdl/icmpr_final.sv */
// Stage three: finish the header checksum and register the reply.
`timescale 1ns / 1ps
module icmpr_final (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  icmpr_pkg::s2_t                  up_data,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic [icmpr_pkg::OUT_DATA_W-1:0] dn_data,
  output logic                            dn_user
);
  import icmpr_pkg::*;

  logic                  v_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic [OUT_DATA_W-1:0] data_nxt;
  logic                  user_r;
  logic [15:0]           fold2;
  logic [15:0]           hcalc;
  logic [15:0]           hsum;

  assign fold2 = up_data.fsum[15:0] + {15'b0, up_data.fsum[16]};
  // a zero checksum goes out as all ones
  assign hcalc = (~fold2 == 16'h0000) ? SUM_ALL_ONES : ~fold2;
  assign hsum  = up_data.mcast ? hcalc : up_data.hsum_in;

  always_comb begin
    if (up_data.keep) begin
      data_nxt = {up_data.icmp_sum, ECHO_REPLY, hsum, up_data.isrc, up_data.rsrc,
                  up_data.dmac, up_data.smac};
    end else begin
      data_nxt = '0;
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
      user_r <= up_data.keep;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;
  assign dn_user  = user_r;

endmodule

/* hdl/icmp_echo_reply_rewriter_unit.sv */
// Top level of the ICMP echo reply rewriter: three-stage header rewrite pipeline.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------
//  in_*    | request   | in_tvalid/in_tready  | in_tdata 280 b, in_tuser 8 b
//  out_*   | reply     | out_tvalid/out_tready| out_tdata 200 b, out_tuser 1 b
//
// One request enters per cycle while in_tready is high. The decode, sum and
// final registers load in turn, and out_tvalid rises once the final register
// holds the reply.
// Every request yields exactly one reply item; out_tuser low marks a drop,
// and then out_tdata is all zeros.
// Reset (rst_n low, synchronous) empties all three stages; payload is not cleared.
// Each stage holds its item while the next is full and stalled; an empty stage
// still takes a request, so bubbles close up under back-pressure.
`timescale 1ns / 1ps
module icmp_echo_reply_rewriter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // dest_mac, source_mac, ip_front_words, ttl_and_proto, ip_hdr_sum_in,
  // ip_source, ip_dest, icmp_subcode, icmp_sum_in
  input  logic [icmpr_pkg::IN_DATA_W-1:0]  in_tdata,
  // icmp_kind
  input  logic [7:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // reply_dest_mac, reply_source_mac, reply_ip_source, reply_ip_dest,
  // reply_ip_hdr_sum, reply_icmp_kind, reply_icmp_sum
  output logic [icmpr_pkg::OUT_DATA_W-1:0] out_tdata,
  // reply_valid
  output logic                            out_tuser
);
  import icmpr_pkg::*;

`include "icmp_echo_reply_rewriter_unit_macros.svh"

  // stage links
  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;

  // Decode: check protocol/type/code, choose the reply source address,
  // sum the fixed header words and finish the incremental ICMP update.
  icmpr_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .up_kind  (in_tuser),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Sum: add both address words of the reply and fold once.
  icmpr_sum u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Final: second fold, complement, multicast select, drop zeroing; this is
  // the output register seen on the out_ channel.
  icmpr_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata),
    .dn_user  (out_tuser)
  );

  // A dropped request must leave no trace in the payload.
  `ICMPR_ASSERT_NOW(a_drop_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0,
                    "dropped reply carries data")
  // A produced reply is always an echo reply.
  `ICMPR_ASSERT_NOW(a_reply_kind, clk, rst_n, out_tvalid && out_tuser,
                    out_tdata[183:176] == ECHO_REPLY, "reply type is not echo reply")
  // An empty decode stage never refuses a request.
  `ICMPR_ASSERT_NOW(a_take_empty, clk, rst_n, !s1_valid, in_tready,
                    "empty pipeline refused a request")
  // An accepted request occupies the decode stage in the next cycle.
  `ICMPR_ASSERT_NEXT(a_enter_s1, clk, rst_n, in_tvalid && in_tready, s1_valid,
                     "accepted request lost at decode")

endmodule
